// File: sv/eltok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eltok_pkg
// Shared types and constants of the expression tokenizer.
// ----------------------------------------------------------------------------
package eltok_pkg;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_COMMENT, M_COMMENT_EOL, M_MINUS, M_PLUS
  } mode_e;

  typedef enum logic [1:0] {NL_NONE, NL_LF, NL_CR} nl_e;

  localparam logic [4:0] K_UNKNOWN  = 5'd0;
  localparam logic [4:0] K_ARROW    = 5'd1;
  localparam logic [4:0] K_AT       = 5'd2;
  localparam logic [4:0] K_COLON    = 5'd3;
  localparam logic [4:0] K_COMMA    = 5'd4;
  localparam logic [4:0] K_COMMENT  = 5'd5;
  localparam logic [4:0] K_END      = 5'd6;
  localparam logic [4:0] K_EQUALS   = 5'd7;
  localparam logic [4:0] K_IDENT    = 5'd8;
  localparam logic [4:0] K_ARRAY    = 5'd9;
  localparam logic [4:0] K_FALSE    = 5'd10;
  localparam logic [4:0] K_QUERY    = 5'd11;
  localparam logic [4:0] K_RESERVED = 5'd12;
  localparam logic [4:0] K_SYMBOLIC = 5'd13;
  localparam logic [4:0] K_TRUE     = 5'd14;
  localparam logic [4:0] K_WIDTH    = 5'd15;
  localparam logic [4:0] K_LBRACE   = 5'd16;
  localparam logic [4:0] K_LPAREN   = 5'd17;
  localparam logic [4:0] K_LSQUARE  = 5'd18;
  localparam logic [4:0] K_NUMBER   = 5'd19;
  localparam logic [4:0] K_RBRACE   = 5'd20;
  localparam logic [4:0] K_RPAREN   = 5'd21;
  localparam logic [4:0] K_RSQUARE  = 5'd22;
  localparam logic [4:0] K_SEMI     = 5'd23;

  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_USC  = 8'h5f;

  // pattern flag bits
  localparam int PF_I = 0;
  localparam int PF_W = 1;
  localparam int PF_FPD = 2;
  localparam int PF_FPX = 3;

  // per-byte class bundle passed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       digit;
    logic       alpha;
    logic       space;
    logic       nl;
    logic [4:0] punct;
    logic       is_punct;
  } cls_t;

  function automatic logic [4:0] kw_kind(input logic [63:0] lc, input logic [3:0] len);
    logic [4:0] k;
    k = K_IDENT;
    if (len == 4'd3 && lc == 64'h666564) k = K_RESERVED;
    else if (len == 4'd3 && lc == 64'h726176) k = K_RESERVED;
    else if (len == 4'd4 && lc == 64'h65757274) k = K_TRUE;
    else if (len == 4'd5 && lc == 64'h7961727261) k = K_ARRAY;
    else if (len == 4'd5 && lc == 64'h65736c6166) k = K_FALSE;
    else if (len == 4'd5 && lc == 64'h7972657571) k = K_QUERY;
    else if (len == 4'd6 && lc == 64'h656e69666564) k = K_RESERVED;
    else if (len == 4'd7 && lc == 64'h6572616c636564) k = K_RESERVED;
    else if (len == 4'd8 && lc == 64'h63696c6f626d7973) k = K_SYMBOLIC;
    return k;
  endfunction

endpackage
`default_nettype wire

// File: sv/eltok_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eltok_front
// Accepts bytes and classifies them into a two-entry queue.
// ----------------------------------------------------------------------------
module eltok_front import eltok_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_req_i,
  input  wire logic       end_of_input_i,
  output logic            q_valid_o,
  input  wire logic       q_ready_i,
  output cls_t            q_data_o
);
  cls_t       c;
  cls_t       buf_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    c = '0;
    c.ch = byte_req_i;
    c.eoi = end_of_input_i;
    c.digit = byte_req_i >= 8'h30 && byte_req_i <= 8'h39;
    c.alpha = (byte_req_i >= 8'h61 && byte_req_i <= 8'h7a) ||
              (byte_req_i >= 8'h41 && byte_req_i <= 8'h5a);
    c.space = byte_req_i == 8'h20 || (byte_req_i >= 8'd9 && byte_req_i <= 8'd13);
    c.nl = byte_req_i == CH_LF || byte_req_i == CH_CR;
    c.is_punct = 1'b1;
    unique case (byte_req_i)
      8'h28: c.punct = K_LPAREN;
      8'h29: c.punct = K_RPAREN;
      8'h2c: c.punct = K_COMMA;
      8'h3a: c.punct = K_COLON;
      8'h3b: c.punct = K_SEMI;
      8'h3d: c.punct = K_EQUALS;
      8'h40: c.punct = K_AT;
      8'h5b: c.punct = K_LSQUARE;
      8'h5d: c.punct = K_RSQUARE;
      8'h7b: c.punct = K_LBRACE;
      8'h7d: c.punct = K_RBRACE;
      default: begin
        c.punct = K_UNKNOWN;
        c.is_punct = 1'b0;
      end
    endcase
  end

  assign in_ready  = cnt_q != 2'd2;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_data_o  = buf_q[rp_q];
  assign push = in_valid && in_ready;
  assign pop  = q_valid_o && q_ready_i;
  assign wp_d = wp_q ^ push;
  assign rp_d = rp_q ^ pop;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= c;
  end
endmodule
`default_nettype wire

// File: sv/eltok_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eltok_back
// Tokenizer state machine; emits up to two tokens per byte via a
// two-entry output queue.
// ----------------------------------------------------------------------------
module eltok_back import eltok_pkg::*; #(
  parameter int CW = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  output logic         q_ready_o,
  input  cls_t         q_data_i,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [4:0]   kind_o,
  output logic [15:0]  start_line_o,
  output logic [15:0]  start_column_o,
  output logic [15:0]  byte_length_o,
  output logic         last_o
);
  localparam logic [CW-1:0] CMAX = '1;
  localparam int RW = 5 + 48 + 1;

  mode_e         mode_q, mode_d;
  nl_e           nl_q, nl_d;
  logic [CW-1:0] line_q, line_d, col_q, col_d;
  logic [CW-1:0] tl_q, tl_d, tc_q, tc_d, tb_q, tb_d;
  logic [63:0]   lc_q, lc_d;
  logic [3:0]    pf_q, pf_d;

  logic [RW-1:0] r0, r1;
  logic [1:0]    n;
  logic [RW-1:0] ob_q [2];
  logic          ob_v_q [2];
  logic          take;
  cls_t          c;
  logic          idle_go;

  function automatic logic [CW-1:0] sinc(input logic [CW-1:0] v);
    return (v == CMAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [RW-1:0] mk(input logic [4:0] k, input logic [CW-1:0] l,
                                       input logic [CW-1:0] cc, input logic [CW-1:0] b);
    logic [15:0] l16, c16, b16;
    l16 = 16'(l);
    c16 = 16'(cc);
    b16 = 16'(b);
    return {k, l16, c16, b16, 1'b0};
  endfunction

  function automatic logic [4:0] classify(input logic [63:0] lc, input logic [3:0] pf,
                                          input logic [CW-1:0] len);
    logic [4:0] k;
    logic [3:0] l4;
    l4 = (len > CW'(8)) ? 4'd9 : 4'(len);
    k = kw_kind(lc, l4);
    if (k == K_IDENT) begin
      if ((pf[PF_I] && len > CW'(1)) || ((pf[PF_FPD] || pf[PF_FPX]) && len > CW'(3)))
        k = K_RESERVED;
      else if (pf[PF_W] && len >= CW'(2)) k = K_WIDTH;
    end
    return k;
  endfunction

  assign c = q_data_i;
  assign q_ready_o = !ob_v_q[0] || (!ob_v_q[1] && out_ready);
  assign take = q_valid_i && q_ready_o;

  always_comb begin
    mode_d = mode_q; nl_d = nl_q; line_d = line_q; col_d = col_q;
    tl_d = tl_q; tc_d = tc_q; tb_d = tb_q; lc_d = lc_q; pf_d = pf_q;
    r0 = '0; r1 = '0; n = 2'd0; idle_go = 1'b0;
    if (c.eoi) begin
      n = 2'd1;
      case (mode_q)
        M_IDENT: r0 = mk(classify(lc_q, pf_q, tb_q), tl_q, tc_q, tb_q);
        M_NUMBER: r0 = mk(K_NUMBER, tl_q, tc_q, tb_q);
        M_COMMENT, M_COMMENT_EOL: r0 = mk(K_COMMENT, tl_q, tc_q, tb_q);
        M_MINUS, M_PLUS: r0 = mk(K_UNKNOWN, tl_q, tc_q, tb_q);
        default: n = 2'd0;
      endcase
      if (n == 2'd0) r0 = mk(K_END, line_q, col_q, '0);
      else r1 = mk(K_END, line_q, col_q, '0);
      n = n + 2'd1;
      mode_d = M_IDLE; nl_d = NL_NONE; line_d = CW'(1); col_d = '0;
      tl_d = '0; tc_d = '0; tb_d = '0; lc_d = '0; pf_d = '0;
    end else if (nl_q != NL_NONE && ((nl_q == NL_CR && c.ch == CH_LF) ||
                                      (nl_q == NL_LF && c.ch == CH_CR))) begin
      nl_d = NL_NONE;
      if (mode_q == M_COMMENT_EOL) begin
        r0 = mk(K_COMMENT, tl_q, tc_q, sinc(tb_q));
        n = 2'd1;
        tb_d = sinc(tb_q);
        mode_d = M_IDLE;
      end
    end else begin
      nl_d = NL_NONE;
      case (mode_q)
        M_IDENT: begin
          if (c.digit || c.alpha || c.ch == CH_USC || c.ch == 8'h2e || c.ch == 8'h2d) begin
            if (tb_q < CW'(8)) lc_d = lc_q | ({56'd0, c.ch} << {tb_q[2:0], 3'd0});
            if (!c.digit) pf_d[PF_W:PF_I] = 2'b00;
            if (tb_q == CW'(2)) begin
              if (lc_q[7:0] == 8'h66 && lc_q[15:8] == 8'h70 && c.digit) pf_d[PF_FPD] = 1'b1;
            end else if (tb_q >= CW'(3) && pf_q[PF_FPD] && !c.digit) begin
              pf_d[PF_FPD] = 1'b0;
              if (c.ch == 8'h2e) pf_d[PF_FPX] = 1'b1;
            end
            tb_d = sinc(tb_q); col_d = sinc(col_q);
          end else begin
            r0 = mk(classify(lc_q, pf_q, tb_q), tl_q, tc_q, tb_q);
            n = 2'd1; idle_go = 1'b1;
          end
        end
        M_NUMBER: begin
          if (c.digit || c.alpha || c.ch == CH_USC) begin
            tb_d = sinc(tb_q); col_d = sinc(col_q);
          end else begin
            r0 = mk(K_NUMBER, tl_q, tc_q, tb_q);
            n = 2'd1; idle_go = 1'b1;
          end
        end
        M_COMMENT: begin
          tb_d = sinc(tb_q);
          if (c.nl) begin
            line_d = sinc(line_q); col_d = '0;
            nl_d = (c.ch == CH_LF) ? NL_LF : NL_CR;
            mode_d = M_COMMENT_EOL;
          end else col_d = sinc(col_q);
        end
        M_COMMENT_EOL: begin
          r0 = mk(K_COMMENT, tl_q, tc_q, tb_q);
          n = 2'd1; idle_go = 1'b1;
        end
        M_MINUS, M_PLUS: begin
          if (mode_q == M_MINUS && c.ch == 8'h3e) begin
            r0 = mk(K_ARROW, tl_q, tc_q, sinc(tb_q));
            n = 2'd1;
            tb_d = sinc(tb_q); col_d = sinc(col_q); mode_d = M_IDLE;
          end else if (c.digit) begin
            tb_d = sinc(tb_q); col_d = sinc(col_q); mode_d = M_NUMBER;
          end else begin
            r0 = mk(K_UNKNOWN, tl_q, tc_q, tb_q);
            n = 2'd1; idle_go = 1'b1;
          end
        end
        default: idle_go = 1'b1;
      endcase
      if (idle_go) begin
        mode_d = M_IDLE;
        if (c.space) begin
          if (c.nl) begin
            line_d = sinc(line_q); col_d = '0;
            nl_d = (c.ch == CH_LF) ? NL_LF : NL_CR;
          end else col_d = sinc(col_q);
        end else begin
          tl_d = line_q; tc_d = col_q; tb_d = CW'(1);
          lc_d = '0; pf_d = '0;
          col_d = sinc(col_q);
          if (c.is_punct || !(c.ch == CH_HASH || c.ch == 8'h2b || c.ch == 8'h2d ||
                              c.digit || c.alpha || c.ch == CH_USC)) begin
            if (n == 2'd0) r0 = mk(c.punct, line_q, col_q, CW'(1));
            else r1 = mk(c.punct, line_q, col_q, CW'(1));
            n = n + 2'd1;
          end else if (c.ch == CH_HASH) mode_d = M_COMMENT;
          else if (c.ch == 8'h2b) mode_d = M_PLUS;
          else if (c.ch == 8'h2d) mode_d = M_MINUS;
          else if (c.digit) mode_d = M_NUMBER;
          else begin
            mode_d = M_IDENT;
            lc_d = {56'd0, c.ch};
            pf_d = {2'b00, c.ch == 8'h77, c.ch == 8'h69};
          end
        end
      end
    end
    if (n == 2'd1) r0[0] = 1'b1;
    if (n == 2'd2) r1[0] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; nl_q <= NL_NONE; line_q <= CW'(1); col_q <= '0;
      tl_q <= '0; tc_q <= '0; tb_q <= '0; lc_q <= '0; pf_q <= '0;
    end else if (take) begin
      mode_q <= mode_d; nl_q <= nl_d; line_q <= line_d; col_q <= col_d;
      tl_q <= tl_d; tc_q <= tc_d; tb_q <= tb_d; lc_q <= lc_d; pf_q <= pf_d;
    end
  end

  // output queue: slot 0 is head
  logic pop;
  assign pop = ob_v_q[0] && out_ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_v_q[0] <= 1'b0;
      ob_v_q[1] <= 1'b0;
    end else begin
      if (take && n != 2'd0) begin
        if (!ob_v_q[0] || (pop && !ob_v_q[1])) begin
          ob_v_q[0] <= 1'b1;
          ob_v_q[1] <= n == 2'd2;
        end else begin
          ob_v_q[0] <= 1'b1;
          ob_v_q[1] <= 1'b1;
        end
      end else if (pop) begin
        ob_v_q[0] <= ob_v_q[1];
        ob_v_q[1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && n != 2'd0) begin
      if (!ob_v_q[0] || (pop && !ob_v_q[1])) begin
        ob_q[0] <= r0;
        ob_q[1] <= r1;
      end else begin
        ob_q[1] <= r0;
      end
    end else if (pop) begin
      ob_q[0] <= ob_q[1];
    end
  end

  assign out_valid = ob_v_q[0];
  assign {kind_o, start_line_o, start_column_o, byte_length_o, last_o} = ob_q[0];
endmodule
`default_nettype wire

// File: sv/expression_language_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expression_language_tokenizer_core
// Streaming byte tokenizer for a small expression language.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the input queue has room. A byte passes
// a classifier and a two-entry queue, then the tokenizer state machine, which
// handles one byte per cycle while the output buffer has room and writes up
// to two tokens into a two-entry output buffer; a byte that yields two tokens
// holds the input while they drain.
module expression_language_tokenizer_core import eltok_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_req_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      kind_o,
  output logic [15:0]     start_line_o,
  output logic [15:0]     start_column_o,
  output logic [15:0]     byte_length_o,
  output logic            last_o
);
  logic q_valid, q_ready;
  cls_t q_data;

  eltok_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .byte_req_i, .end_of_input_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  eltok_back #(.CW(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid, .out_ready, .kind_o, .start_line_o, .start_column_o,
    .byte_length_o, .last_o
  );
endmodule
`default_nettype wire

// File: sv/eltok_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eltok_checker
// Port-level checks for the tokenizer.
// ----------------------------------------------------------------------------
module eltok_checker import eltok_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  kind_o,
  input wire logic [15:0] start_line_o,
  input wire logic [15:0] byte_length_o,
  input wire logic        last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(kind_o))
    else $error("output changed while stalled");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> kind_o <= K_SEMI) else $error("bad kind");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind_o == K_END |-> last_o && byte_length_o == 16'd0)
    else $error("bad end token");
  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> start_line_o != 16'd0) else $error("line zero");
endmodule

bind expression_language_tokenizer_core eltok_checker u_chk (
  .clk_i, .rst_ni, .out_valid, .out_ready, .kind_o, .start_line_o,
  .byte_length_o, .last_o
);
`default_nettype wire
